/* hdl/gnfcs_pkg.sv */
// Shared types, constants and the microcode program of the nearest free cell search.
package gnfcs_pkg;

   // signed width of probe coordinates and grid bounds
   localparam int CW       = 11;
   localparam int PCW      = 4;
   localparam int NUM_DIRS = 8;

   typedef logic [PCW-1:0] pc_type;
   typedef logic [2:0]     dir_type;

   localparam pc_type PC_CLEAR      = 4'd0;
   localparam pc_type PC_IDLE       = 4'd1;
   localparam pc_type PC_DISPATCH   = 4'd2;
   localparam pc_type PC_TILE_CHK   = 4'd3;
   localparam pc_type PC_TILE_RD    = 4'd4;
   localparam pc_type PC_TILE_WR    = 4'd5;
   localparam pc_type PC_START_RD   = 4'd6;
   localparam pc_type PC_START_TEST = 4'd7;
   localparam pc_type PC_PROBE_RD   = 4'd8;
   localparam pc_type PC_PROBE_TEST = 4'd9;
   localparam pc_type PC_EMIT       = 4'd10;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_TILE_INIT,
      OP_TILE_RD,
      OP_TILE_WR,
      OP_START_RD,
      OP_START_TEST,
      OP_PROBE_RD,
      OP_PROBE_TEST,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      COND_ALWAYS,
      COND_REQ,
      COND_MODE0,
      COND_TILE_SKIP,
      COND_CLR_LAST,
      COND_TILE_LAST,
      COND_OFF_GRID,
      COND_START_STOP,
      COND_PROBE_STOP,
      COND_OUT_BUSY
   } cond_type;

   typedef enum logic {
      REG_TILES_WIDE,
      REG_TILES_HIGH
   } reg_type;

   typedef enum logic [1:0] {
      STEP_ZERO,
      STEP_POS,
      STEP_NEG
   } step_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   tgt_t;
      pc_type   tgt_f;
   } uword_type;

   typedef struct packed {
      logic mode0;
      logic tile_skip;
      logic clr_last;
      logic tile_last;
      logic off_grid;
      logic start_stop;
      logic probe_stop;
   } dp_flags_type;

   // probe order N, E, S, W, NE, SE, SW, NW; north is decreasing row
   function automatic step_type dir_dx(input dir_type k);
      case (k)
         3'd1, 3'd4, 3'd5: dir_dx = STEP_POS;
         3'd3, 3'd6, 3'd7: dir_dx = STEP_NEG;
         default:          dir_dx = STEP_ZERO;
      endcase
   endfunction

   function automatic step_type dir_dy(input dir_type k);
      case (k)
         3'd2, 3'd5, 3'd6: dir_dy = STEP_POS;
         3'd0, 3'd4, 3'd7: dir_dy = STEP_NEG;
         default:          dir_dy = STEP_ZERO;
      endcase
   endfunction

   // control store: op, branch condition, target if true, target if false
   function automatic uword_type ucode_rom(input pc_type pc);
      case (pc)
         PC_CLEAR:      ucode_rom = '{OP_CLEAR,      COND_CLR_LAST,   PC_IDLE,     PC_CLEAR};
         PC_IDLE:       ucode_rom = '{OP_ACCEPT,     COND_REQ,        PC_DISPATCH, PC_IDLE};
         PC_DISPATCH:   ucode_rom = '{OP_NONE,       COND_MODE0,      PC_TILE_CHK, PC_START_RD};
         PC_TILE_CHK:   ucode_rom = '{OP_TILE_INIT,  COND_TILE_SKIP,  PC_EMIT,     PC_TILE_RD};
         PC_TILE_RD:    ucode_rom = '{OP_TILE_RD,    COND_ALWAYS,     PC_TILE_WR,  PC_TILE_WR};
         PC_TILE_WR:    ucode_rom = '{OP_TILE_WR,    COND_TILE_LAST,  PC_EMIT,     PC_TILE_RD};
         PC_START_RD:   ucode_rom = '{OP_START_RD,   COND_OFF_GRID,   PC_EMIT,     PC_START_TEST};
         PC_START_TEST: ucode_rom = '{OP_START_TEST, COND_START_STOP, PC_EMIT,     PC_PROBE_RD};
         PC_PROBE_RD:   ucode_rom = '{OP_PROBE_RD,   COND_ALWAYS,     PC_PROBE_TEST, PC_PROBE_TEST};
         PC_PROBE_TEST: ucode_rom = '{OP_PROBE_TEST, COND_PROBE_STOP, PC_EMIT,     PC_PROBE_RD};
         PC_EMIT:       ucode_rom = '{OP_EMIT,       COND_OUT_BUSY,   PC_EMIT,     PC_IDLE};
         default:       ucode_rom = '{OP_NONE,       COND_ALWAYS,     PC_IDLE,     PC_IDLE};
      endcase
   endfunction

endpackage

/* hdl/gnfcs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module gnfcs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hdl/gnfcs_seq.sv */
// Microcode sequencer: step counter, control store lookup and conditional branch.
module gnfcs_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  gnfcs_pkg::dp_flags_type flags_i,
   input  logic                   req_fire_i,
   input  logic                   out_busy_i,
   output gnfcs_pkg::op_type      op_o
);

   gnfcs_pkg::pc_type    pc_ff;
   gnfcs_pkg::pc_type    pc_in;
   gnfcs_pkg::uword_type uw;
   logic                 take;

   assign uw = gnfcs_pkg::ucode_rom(pc_ff);

   always_comb begin
      case (uw.cond)
         gnfcs_pkg::COND_ALWAYS:     take = 1'b1;
         gnfcs_pkg::COND_REQ:        take = req_fire_i;
         gnfcs_pkg::COND_MODE0:      take = flags_i.mode0;
         gnfcs_pkg::COND_TILE_SKIP:  take = flags_i.tile_skip;
         gnfcs_pkg::COND_CLR_LAST:   take = flags_i.clr_last;
         gnfcs_pkg::COND_TILE_LAST:  take = flags_i.tile_last;
         gnfcs_pkg::COND_OFF_GRID:   take = flags_i.off_grid;
         gnfcs_pkg::COND_START_STOP: take = flags_i.start_stop;
         gnfcs_pkg::COND_PROBE_STOP: take = flags_i.probe_stop;
         gnfcs_pkg::COND_OUT_BUSY:   take = out_busy_i;
         default:                    take = 1'b0;
      endcase
      pc_in = take ? uw.tgt_t : uw.tgt_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= gnfcs_pkg::PC_CLEAR;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op_o = uw.op;

endmodule

/* hdl/gnfcs_dp.sv */
// Datapath: item registers, blocked-node bitmap, probe generator and result registers.
module gnfcs_dp #(
   parameter int SUBDIV    = 4,
   parameter int MAX_TILES = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  gnfcs_pkg::op_type              op_i,
   input  logic                           req_fire_i,
   input  logic                           mode_i,
   input  logic [7:0]                     pos_x_i,
   input  logic [7:0]                     pos_y_i,
   input  logic                           tile_open_i,
   input  logic [7:0]                     search_range_i,
   input  logic [$clog2(MAX_TILES+1)-1:0] tiles_wide_i,
   input  logic [$clog2(MAX_TILES+1)-1:0] tiles_high_i,
   output gnfcs_pkg::dp_flags_type        flags_o,
   output logic                           found_o,
   output logic [7:0]                     hit_x_o,
   output logic [7:0]                     hit_y_o
);

   localparam int NODE_DIM = MAX_TILES * SUBDIV + 1;
   localparam int AW       = $clog2(NODE_DIM);
   localparam int CW       = gnfcs_pkg::CW;
   localparam logic [NODE_DIM-1:0] TILE_MASK = NODE_DIM'((1 << (SUBDIV + 1)) - 1);

   logic                  mode0_ff, mode0_in;
   logic [7:0]            px_ff, px_in;
   logic [7:0]            py_ff, py_in;
   logic                  topen_ff, topen_in;
   logic [7:0]            range_ff, range_in;
   logic                  found_ff, found_in;
   logic [7:0]            hx_ff, hx_in;
   logic [7:0]            hy_ff, hy_in;
   logic [AW-1:0]         cnt_ff, cnt_in;
   logic [7:0]            d_ff, d_in;
   gnfcs_pkg::dir_type    k_ff, k_in;
   logic signed [CW-1:0]  cx_ff, cx_in;
   logic signed [CW-1:0]  cy_ff, cy_in;
   logic                  pok_ff, pok_in;

   logic signed [CW-1:0]  cols, rows, px_s, py_s, d_s, cx, cy;
   logic                  start_ok, probe_ok, start_open, probe_open;
   logic [AW-1:0]         tile_row, raddr, waddr;
   logic [NODE_DIM-1:0]   row_q, wdata, mask;
   logic                  we;

   // bitmap holds a 1 for each blocked node, so the clearing pass writes zeros
   gnfcs_ram #(
      .WIDTH (NODE_DIM),
      .DEPTH (NODE_DIM)
   ) u_map (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (row_q)
   );

   assign cols = $signed(CW'(tiles_wide_i * SUBDIV + 1));
   assign rows = $signed(CW'(tiles_high_i * SUBDIV + 1));
   assign px_s = $signed(CW'(px_ff));
   assign py_s = $signed(CW'(py_ff));
   assign d_s  = $signed(CW'(d_ff));

   always_comb begin
      case (gnfcs_pkg::dir_dx(k_ff))
         gnfcs_pkg::STEP_POS: cx = px_s + d_s;
         gnfcs_pkg::STEP_NEG: cx = px_s - d_s;
         default:             cx = px_s;
      endcase
      case (gnfcs_pkg::dir_dy(k_ff))
         gnfcs_pkg::STEP_POS: cy = py_s + d_s;
         gnfcs_pkg::STEP_NEG: cy = py_s - d_s;
         default:             cy = py_s;
      endcase
   end

   assign start_ok   = (px_s < cols) && (py_s < rows);
   assign probe_ok   = (cx >= 0) && (cx < cols) && (cy >= 0) && (cy < rows);
   assign start_open = !row_q[AW'(py_ff)];
   assign probe_open = !row_q[cy_ff[AW-1:0]];

   // tile k-th node column and its node rows as a bit mask within the row
   assign tile_row = AW'(px_ff * SUBDIV + cnt_ff);
   assign mask     = TILE_MASK << AW'(py_ff * SUBDIV);

   always_comb begin
      case (op_i)
         gnfcs_pkg::OP_TILE_RD:  raddr = tile_row;
         gnfcs_pkg::OP_START_RD: raddr = start_ok ? AW'(px_ff) : '0;
         gnfcs_pkg::OP_PROBE_RD: raddr = probe_ok ? cx[AW-1:0] : '0;
         default:                raddr = '0;
      endcase
   end

   assign we    = (op_i == gnfcs_pkg::OP_CLEAR) || (op_i == gnfcs_pkg::OP_TILE_WR);
   assign waddr = (op_i == gnfcs_pkg::OP_CLEAR) ? cnt_ff : tile_row;
   assign wdata = (op_i == gnfcs_pkg::OP_CLEAR) ? '0 : (row_q | mask);

   always_comb begin
      mode0_in = mode0_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      topen_in = topen_ff;
      range_in = range_ff;
      found_in = found_ff;
      hx_in    = hx_ff;
      hy_in    = hy_ff;
      cnt_in   = cnt_ff;
      d_in     = d_ff;
      k_in     = k_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      pok_in   = pok_ff;
      case (op_i)
         gnfcs_pkg::OP_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
         end
         gnfcs_pkg::OP_ACCEPT: begin
            if (req_fire_i) begin
               mode0_in = !mode_i;
               px_in    = pos_x_i;
               py_in    = pos_y_i;
               topen_in = tile_open_i;
               range_in = search_range_i;
               found_in = 1'b0;
               hx_in    = '0;
               hy_in    = '0;
            end
         end
         gnfcs_pkg::OP_TILE_INIT: begin
            cnt_in = '0;
         end
         gnfcs_pkg::OP_TILE_WR: begin
            cnt_in = cnt_ff + 1'b1;
         end
         gnfcs_pkg::OP_START_RD: begin
            d_in = 8'd1;
            k_in = '0;
         end
         gnfcs_pkg::OP_START_TEST: begin
            if (start_open) begin
               found_in = 1'b1;
               hx_in    = px_ff;
               hy_in    = py_ff;
            end
         end
         gnfcs_pkg::OP_PROBE_RD: begin
            cx_in  = cx;
            cy_in  = cy;
            pok_in = probe_ok;
         end
         gnfcs_pkg::OP_PROBE_TEST: begin
            if (pok_ff && probe_open) begin
               found_in = 1'b1;
               hx_in    = cx_ff[7:0];
               hy_in    = cy_ff[7:0];
            end else if (k_ff == 3'(gnfcs_pkg::NUM_DIRS - 1)) begin
               k_in = '0;
               d_in = d_ff + 1'b1;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      mode0_ff <= mode0_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      topen_ff <= topen_in;
      range_ff <= range_in;
      found_ff <= found_in;
      hx_ff    <= hx_in;
      hy_ff    <= hy_in;
      d_ff     <= d_in;
      k_ff     <= k_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      pok_ff   <= pok_in;
   end

   assign flags_o.mode0      = mode0_ff;
   assign flags_o.tile_skip  = topen_ff || (px_ff >= tiles_wide_i) || (py_ff >= tiles_high_i);
   assign flags_o.clr_last   = (cnt_ff == AW'(NODE_DIM - 1));
   assign flags_o.tile_last  = (cnt_ff == AW'(SUBDIV));
   assign flags_o.off_grid   = !start_ok;
   assign flags_o.start_stop = start_open || (range_ff == 8'd0);
   assign flags_o.probe_stop = (pok_ff && probe_open) ||
                               ((k_ff == 3'(gnfcs_pkg::NUM_DIRS - 1)) && (d_ff == range_ff));

   assign found_o = found_ff;
   assign hit_x_o = hx_ff;
   assign hit_y_o = hy_ff;

endmodule

/* hdl/grid_nearest_free_cell_search.sv */
// Mode 0: dispatch, tile check, then a read and a write of each node column of a blocked tile.
// Mode 1: a start read and test, then a read and a test per probe, 8 probes per distance step.
// One item at a time; the sequencer returns to accept as the result loads.
// Each probe is a bitmap row read and a test, so the single memory read port sets the pace.
// Reset: synchronous; then a clearing pass over all MAX_TILES*SUBDIV+1 bitmap rows (129 by default)
// marks every node pathable with req_tready low; register writes are taken throughout.
module grid_nearest_free_cell_search #(
   parameter int SUBDIV    = 4,
   parameter int MAX_TILES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // pos_x, pos_y, tile_open, search_range, zero fill
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found, hit_x, hit_y, zero fill
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [5:0]  csr_wdata
);

   localparam int TW        = $clog2(MAX_TILES + 1);
   localparam int RST_TILES = (32 > MAX_TILES) ? MAX_TILES : 32;

   logic [TW-1:0]           twc_ff, twc_in;
   logic [TW-1:0]           thc_ff, thc_in;
   logic [TW-1:0]           clamped;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [23:0]             rsp_data_ff, rsp_data_in;
   logic                    req_fire, out_busy, emit_go;
   logic                    found;
   logic [7:0]              hit_x, hit_y;
   gnfcs_pkg::op_type       op;
   gnfcs_pkg::dp_flags_type flags;

   gnfcs_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .flags_i    (flags),
      .req_fire_i (req_fire),
      .out_busy_i (out_busy),
      .op_o       (op)
   );

   gnfcs_dp #(
      .SUBDIV    (SUBDIV),
      .MAX_TILES (MAX_TILES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .op_i           (op),
      .req_fire_i     (req_fire),
      .mode_i         (req_tuser),
      .pos_x_i        (req_tdata[7:0]),
      .pos_y_i        (req_tdata[15:8]),
      .tile_open_i    (req_tdata[16]),
      .search_range_i (req_tdata[24:17]),
      .tiles_wide_i   (twc_ff),
      .tiles_high_i   (thc_ff),
      .flags_o        (flags),
      .found_o        (found),
      .hit_x_o        (hit_x),
      .hit_y_o        (hit_y)
   );

   assign req_tready = (op == gnfcs_pkg::OP_ACCEPT);
   assign req_fire   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign emit_go    = (op == gnfcs_pkg::OP_EMIT) && !out_busy;

   // tile counts are held already clamped to 1..MAX_TILES
   always_comb begin
      if (csr_wdata == 6'd0) begin
         clamped = TW'(1);
      end else if (32'(csr_wdata) > MAX_TILES) begin
         clamped = TW'(MAX_TILES);
      end else begin
         clamped = TW'(csr_wdata);
      end
      twc_in = twc_ff;
      thc_in = thc_ff;
      if (csr_we && (csr_addr == gnfcs_pkg::REG_TILES_WIDE)) begin
         twc_in = clamped;
      end
      if (csr_we && (csr_addr == gnfcs_pkg::REG_TILES_HIGH)) begin
         thc_in = clamped;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, hit_y, hit_x, found};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         twc_ff       <= TW'(RST_TILES);
         thc_ff       <= TW'(RST_TILES);
         rsp_valid_ff <= 1'b0;
      end else begin
         twc_ff       <= twc_in;
         thc_ff       <= thc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // one item in flight: intake closes right after a beat is taken
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // a result appears only from the emit step of the program
   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(op == gnfcs_pkg::OP_EMIT))
      else $error("result valid raised outside the emit step");

   // the clearing pass keeps intake closed right after reset
   a_clear_closed: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_tready)
      else $error("input ready during bitmap clearing");

   // a mode 0 item never reports a hit
   a_mode0_quiet: assert property (@(posedge clock) disable iff (reset)
      (emit_go && flags.mode0) |=> !rsp_tdata[0])
      else $error("mode 0 result with found set");

endmodule

/* dv/grid_nearest_free_cell_search_tb.sv */
// Self-checking testbench for grid_nearest_free_cell_search: tile blocking and nearest open node search.
`timescale 1ns / 1ps

module grid_nearest_free_cell_search_tb;

   localparam int SUBDIV      = 4;
   localparam int MAX_TILES   = 32;
   localparam int NODE_DIM    = MAX_TILES * SUBDIV + 1;
   localparam int CYCLE_LIMIT = 10_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam bit MODE_TILE   = 1'b0;
   localparam bit MODE_SEARCH = 1'b1;

   typedef struct packed {
      bit       mode;
      bit [7:0] pos_x;
      bit [7:0] pos_y;
      bit       tile_open;
      bit [7:0] search_range;
   } probe_req_type;

   typedef struct packed {
      bit       found;
      bit [7:0] hit_x;
      bit [7:0] hit_y;
   } hit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // pos_x, pos_y, tile_open, search_range, zero fill
   logic        req_tuser = 1'b0; // mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // found, hit_x, hit_y, zero fill
   logic        csr_we = 1'b0;
   logic        csr_addr = gnfcs_pkg::REG_TILES_WIDE;
   logic [5:0]  csr_wdata = '0;

   // predictor state
   bit         node_free [NODE_DIM][NODE_DIM];
   bit [5:0]   tiles_wide_m = 6'd32;
   bit [5:0]   tiles_high_m = 6'd32;

   probe_req_type pending_q [$];
   hit_type       hit_q [$];
   probe_req_type offer_item;
   bit [7:0]   blk_x_q [$];
   bit [7:0]   blk_y_q [$];
   bit         beat_taken = 1'b0;
   bit         rx_hold = 1'b0;
   bit         pressure_go = 1'b0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;
   int         issued_cnt = 0;
   int         accepted_cnt = 0;
   int         err_cnt = 0;

   grid_nearest_free_cell_search #(
      .SUBDIV    (SUBDIV),
      .MAX_TILES (MAX_TILES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_tiles(bit [5:0] t);
      if (t == 0) return 1;
      if (t > MAX_TILES) return MAX_TILES;
      return int'(t);
   endfunction

   function automatic bit node_on_grid(int x, int y);
      return x >= 0 && y >= 0 && x < eff_tiles(tiles_wide_m) * SUBDIV + 1 &&
             y < eff_tiles(tiles_high_m) * SUBDIV + 1;
   endfunction

   // applies one beat to the bitmap and returns the expected result
   function automatic hit_type nearest_open(probe_req_type r);
      hit_type h;
      int   px, py, cx, cy, sx, sy, d, k, l;
      h  = '0;
      px = int'(r.pos_x);
      py = int'(r.pos_y);
      if (r.mode == MODE_TILE) begin
         if (!r.tile_open && px < eff_tiles(tiles_wide_m) && py < eff_tiles(tiles_high_m)) begin
            for (k = 0; k <= SUBDIV; k++)
               for (l = 0; l <= SUBDIV; l++)
                  node_free[px * SUBDIV + k][py * SUBDIV + l] = 1'b0;
         end
      end else if (node_on_grid(px, py)) begin
         if (node_free[px][py]) begin
            h.found = 1'b1;
            h.hit_x = 8'(px);
            h.hit_y = 8'(py);
         end else begin
            for (d = 1; d <= r.search_range && !h.found; d++) begin
               for (k = 0; k < 8 && !h.found; k++) begin
                  // N, E, S, W, NE, SE, SW, NW; north is decreasing row
                  case (k)
                     0:       begin sx =  0; sy = -1; end
                     1:       begin sx =  1; sy =  0; end
                     2:       begin sx =  0; sy =  1; end
                     3:       begin sx = -1; sy =  0; end
                     4:       begin sx =  1; sy = -1; end
                     5:       begin sx =  1; sy =  1; end
                     6:       begin sx = -1; sy =  1; end
                     default: begin sx = -1; sy = -1; end
                  endcase
                  cx = px + sx * d;
                  cy = py + sy * d;
                  if (node_on_grid(cx, cy) && node_free[cx][cy]) begin
                     h.found = 1'b1;
                     h.hit_x = 8'(cx);
                     h.hit_y = 8'(cy);
                  end
               end
            end
         end
      end
      return h;
   endfunction

   function automatic probe_req_type gen_item();
      probe_req_type r;
      int         tw, th, pick, idx;
      tw = eff_tiles(tiles_wide_m);
      th = eff_tiles(tiles_high_m);
      r.tile_open    = 1'($urandom_range(1));
      r.search_range = 8'($urandom_range(255));
      if ($urandom_range(99) < 35) begin
         r.mode = MODE_TILE;
         if ($urandom_range(9) == 0) begin
            r.pos_x = 8'($urandom_range(255));
            r.pos_y = 8'($urandom_range(255));
         end else begin
            r.pos_x = 8'($urandom_range(tw - 1));
            r.pos_y = 8'($urandom_range(th - 1));
         end
         r.tile_open = ($urandom_range(99) < 35);
         if (!r.tile_open && r.pos_x < tw && r.pos_y < th) begin
            blk_x_q.insert(blk_x_q.size(), r.pos_x);
            blk_y_q.insert(blk_y_q.size(), r.pos_y);
         end
      end else begin
         r.mode = MODE_SEARCH;
         pick = $urandom_range(99);
         if (pick < 10) begin
            r.pos_x = 8'($urandom_range(255));
            r.pos_y = 8'($urandom_range(255));
         end else if (pick < 70 && blk_x_q.size() > 0) begin
            // start inside a blocked square so the probe loop runs
            idx = $urandom_range(blk_x_q.size() - 1);
            r.pos_x = 8'(blk_x_q[idx] * SUBDIV + $urandom_range(SUBDIV));
            r.pos_y = 8'(blk_y_q[idx] * SUBDIV + $urandom_range(SUBDIV));
         end else begin
            r.pos_x = 8'($urandom_range(tw * SUBDIV));
            r.pos_y = 8'($urandom_range(th * SUBDIV));
         end
         pick = $urandom_range(99);
         if (pick < 70)      r.search_range = 8'($urandom_range(6));
         else if (pick < 95) r.search_range = 8'($urandom_range(20, 7));
         else                r.search_range = 8'($urandom_range(255));
      end
      return r;
   endfunction

   task automatic push_item(bit mode, bit [7:0] x, bit [7:0] y, bit open, bit [7:0] range);
      probe_req_type r;
      r = '{mode, x, y, open, range};
      pending_q.insert(pending_q.size(), r);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t %s: got %0d expected %0d", $time, what, got, want);
      err_cnt++;
   endtask

   task automatic wait_idle(int tail);
      while (pending_q.size() != 0 || accepted_cnt != issued_cnt || hit_q.size() != 0)
         @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic write_reg(gnfcs_pkg::reg_type idx, bit [5:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == gnfcs_pkg::REG_TILES_WIDE) tiles_wide_m = val;
      else                                  tiles_high_m = val;
   endtask

   task automatic set_size(bit [5:0] w, bit [5:0] h);
      wait_idle(10);
      write_reg(gnfcs_pkg::REG_TILES_WIDE, w);
      write_reg(gnfcs_pkg::REG_TILES_HIGH, h);
   endtask

   task automatic run_random(int n, int send_pct, int recv_pct);
      int i;
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (i = 0; i < n; i++) pending_q.insert(pending_q.size(), gen_item());
      wait_idle(0);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || beat_taken) begin
         if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            offer_item = pending_q.pop_front();
            issued_cnt++;
            req_tvalid <= 1'b1;
            req_tuser  <= offer_item.mode;
            req_tdata  <= {7'd0, offer_item.search_range, offer_item.tile_open,
                           offer_item.pos_y, offer_item.pos_x};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      wait (pressure_go);
      @(posedge clock);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_hold = 1'b0;
   end

   // monitor and scoreboard
   always @(posedge clock) begin : mon
      hit_type want;
      beat_taken = 1'b0;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (hit_q.size() == 0) begin
               report_mismatch("unexpected result beat", int'(rsp_tdata), 0);
            end else begin
               want = hit_q.pop_front();
               if (rsp_tdata[0] != want.found)
                  report_mismatch("found", int'(rsp_tdata[0]), int'(want.found));
               if (rsp_tdata[8:1] != want.hit_x)
                  report_mismatch("hit_x", int'(rsp_tdata[8:1]), int'(want.hit_x));
               if (rsp_tdata[16:9] != want.hit_y)
                  report_mismatch("hit_y", int'(rsp_tdata[16:9]), int'(want.hit_y));
            end
         end
         if (req_tvalid && req_tready) begin
            beat_taken = 1'b1;
            hit_q.insert(hit_q.size(), nearest_open(offer_item));
            accepted_cnt++;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("grid_nearest_free_cell_search: mismatch");
      $finish;
   end

   initial begin : stim
      int x, y;
      for (x = 0; x < NODE_DIM; x++)
         for (y = 0; y < NODE_DIM; y++)
            node_free[x][y] = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full-size grid
      set_size(6'd32, 6'd32);
      push_item(MODE_SEARCH, 8'd0,   8'd0,   1'b1, 8'd0);    // open start, zero range
      push_item(MODE_SEARCH, 8'd128, 8'd128, 1'b0, 8'd255);  // far corner, open
      push_item(MODE_SEARCH, 8'd129, 8'd0,   1'b1, 8'd3);    // one past the edge
      push_item(MODE_SEARCH, 8'd255, 8'd255, 1'b1, 8'd255);
      push_item(MODE_TILE,   8'd0,   8'd0,   1'b0, 8'd255);  // block corner tile
      push_item(MODE_TILE,   8'd1,   8'd0,   1'b1, 8'd0);    // open report, no change
      push_item(MODE_TILE,   8'd32,  8'd0,   1'b0, 8'd0);    // tile off the map
      push_item(MODE_TILE,   8'd0,   8'd255, 1'b0, 8'd0);
      push_item(MODE_TILE,   8'd255, 8'd255, 1'b1, 8'd255);
      push_item(MODE_SEARCH, 8'd0,   8'd0,   1'b0, 8'd0);    // blocked start, zero range
      push_item(MODE_SEARCH, 8'd0,   8'd0,   1'b0, 8'd255);
      push_item(MODE_SEARCH, 8'd2,   8'd2,   1'b1, 8'd255);
      push_item(MODE_TILE,   8'd31,  8'd31,  1'b0, 8'd0);
      push_item(MODE_SEARCH, 8'd128, 8'd128, 1'b0, 8'd255);
      push_item(MODE_SEARCH, 8'd126, 8'd126, 1'b1, 8'd2);
      wait_idle(0);

      // directed: shrunken grid, every node blocked
      set_size(6'd1, 6'd1);
      push_item(MODE_SEARCH, 8'd2, 8'd2, 1'b0, 8'd255);
      push_item(MODE_SEARCH, 8'd5, 8'd0, 1'b0, 8'd1);
      push_item(MODE_TILE,   8'd1, 8'd0, 1'b0, 8'd0);
      wait_idle(0);
      set_size(6'd0, 6'd0);
      push_item(MODE_SEARCH, 8'd4, 8'd4, 1'b1, 8'd4);
      wait_idle(0);
      set_size(6'd63, 6'd33);
      push_item(MODE_SEARCH, 8'd4, 8'd4, 1'b1, 8'd4);
      push_item(MODE_SEARCH, 8'd128, 8'd0, 1'b1, 8'd1);
      wait_idle(0);

      // random phases
      set_size(6'd32, 6'd32);
      run_random(100, 0, 0);
      set_size(6'd4, 6'd3);
      run_random(80, 88, 0);
      set_size(6'd32, 6'd32);
      run_random(100, 0, 88);
      set_size(6'd0, 6'd63);
      run_random(80, 12, 12);
      set_size(6'd63, 6'd0);
      pressure_go = 1'b1;
      run_random(80, 0, 0);
      set_size(6'($urandom_range(63)), 6'($urandom_range(63)));
      run_random(100, 12, 12);
      set_size(6'd2, 6'd2);
      run_random(60, 0, 0);
      set_size(6'd32, 6'd32);
      run_random(100, 12, 12);

      repeat (50) @(posedge clock);
      if (err_cnt == 0)
         $display("grid_nearest_free_cell_search: match");
      else
         $display("grid_nearest_free_cell_search: mismatch");
      $finish;
   end

endmodule

/* sim.f */
hdl/gnfcs_pkg.sv
hdl/gnfcs_ram.sv
hdl/gnfcs_seq.sv
hdl/gnfcs_dp.sv
hdl/grid_nearest_free_cell_search.sv
dv/grid_nearest_free_cell_search_tb.sv
